// ===== hdl/ssq_pkg.sv =====
// Shared types and constants for the stable sorted priority queue.
// No dependencies; compiled first.
package ssq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int OCC_W  = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_DEQUEUED  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t fresh;
  } cell_ctl_t;

endpackage

// ===== hdl/ssq_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
// Depends on ssq_pkg.
interface ssq_req_if;
  import ssq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DATA_W-1:0] data_value;
  logic signed [PRIO_W-1:0] item_priority;

  modport source (output valid, command, data_value, item_priority, input ready);
  modport sink   (input valid, command, data_value, item_priority, output ready);
endinterface

interface ssq_rsp_if;
  import ssq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] out_data;
  logic signed [PRIO_W-1:0] out_priority;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, out_data, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_data, out_priority, occupancy, output ready);
endinterface

// ===== hdl/ssq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it to the new
// priority and shifts right on insert or left on removal. Depends on ssq_pkg.
module ssq_cell (
  input  logic               clk,
  input  ssq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               left_le,
  input  ssq_pkg::entry_t    left_entry,
  input  ssq_pkg::entry_t    right_entry,
  output ssq_pkg::entry_t    entry,
  output logic               le
);
  import ssq_pkg::*;

  entry_t entry_q;
  entry_t entry_next;

  assign entry = entry_q;
  assign le    = occupied && ($signed(entry_q.prio) <= $signed(ctl.fresh.prio));

  always_comb begin
    entry_next = entry_q;
    if (ctl.enq) begin
      if (!le) begin
        entry_next = left_le ? ctl.fresh : left_entry;
      end
    end else if (ctl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_q <= entry_next;
  end

endmodule

// ===== hdl/stable_sorted_priority_queue.sv =====
// Top level: chain of DEPTH sorted cells, entry counter and response register.
// Depends on ssq_pkg, ssq_if, ssq_cell.
//
//  channel  modport  payload                                      role
//  req      sink     command, data_value, item_priority           enqueue/dequeue request
//  rsp      source   status, out_data, out_priority, occupancy    one response per request
//
// One request per cycle while req.ready is high: every cell compares and shifts in
// the accepting cycle, the response appears in the registered output the cycle after.
// req.ready is low only while a response waits and rsp.ready is low.
// Synchronous reset empties the queue (count to zero); slot contents are not cleared.
module stable_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  ssq_req_if.sink    req,
  ssq_rsp_if.source  rsp
);
  import ssq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              rsp_valid;
  status_t           status;
  logic [DATA_W-1:0] out_data;
  logic [PRIO_W-1:0] out_priority;

  logic      accept;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;
  entry_t    cell_entry [DEPTH];
  logic      cell_le    [DEPTH];

  assign req.ready        = !rsp_valid || rsp.ready;
  assign accept           = req.valid && req.ready;
  assign full             = (count == CW'(DEPTH));
  assign empty            = (count == '0);

  assign ctl.enq          = accept && (req.command == CMD_ENQ) && !full;
  assign ctl.deq          = accept && (req.command == CMD_DEQ) && !empty;
  assign ctl.fresh.data   = req.data_value;
  assign ctl.fresh.prio   = req.item_priority;

  always_comb begin
    count_next = count;
    if (ctl.enq) begin
      count_next = count + CW'(1);
    end else if (ctl.deq) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_le;

    if (i == 0) begin : g_head
      assign left_entry = ctl.fresh;
      assign left_le    = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    ssq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CW'(i) < count),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .le          (cell_le[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      out_data     <= '0;
      out_priority <= '0;
      if (req.command == CMD_ENQ) begin
        status <= full ? ST_FULL : ST_ENQUEUED;
      end else if (empty) begin
        status <= ST_UNDERFLOW;
      end else begin
        status       <= ST_DEQUEUED;
        out_data     <= cell_entry[0].data;
        out_priority <= cell_entry[0].prio;
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = status;
  assign rsp.out_data     = out_data;
  assign rsp.out_priority = out_priority;
  assign rsp.occupancy    = OCC_W'(count);

endmodule

// ===== hdl/ssq_checker.sv =====
// Port-level assertions for the priority queue, bound to the top level.
// Depends on ssq_pkg and stable_sorted_priority_queue.
module ssq_checker #(
  parameter int DEPTH = 16
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [1:0]                status,
  input logic [ssq_pkg::DATA_W-1:0] out_data,
  input logic [ssq_pkg::PRIO_W-1:0] out_priority,
  input logic [ssq_pkg::OCC_W-1:0]  occupancy
);
  import ssq_pkg::*;

  localparam logic [OCC_W-1:0] DEPTH_LOW = OCC_W'(DEPTH);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(status) && $stable(out_data) && $stable(out_priority)
      && $stable(occupancy))
    else $error("response changed while stalled");

  a_req_to_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request produced no response");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_DEQUEUED) |-> (out_data == '0) && (out_priority == '0))
    else $error("payload not zero on non-dequeue response");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_UNDERFLOW) |-> occupancy == '0)
    else $error("underflow reported with entries held");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> occupancy == DEPTH_LOW)
    else $error("full reported below capacity");

endmodule

bind stable_sorted_priority_queue ssq_checker #(.DEPTH(DEPTH)) u_ssq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .out_data     (rsp.out_data),
  .out_priority (rsp.out_priority),
  .occupancy    (rsp.occupancy)
);
